[src/tibs_pkg.sv]
// Shared constants, codes and types of the tile index binary search block.
package tibs_pkg;

  localparam int TABLE_DEPTH    = 4096;
  localparam int MAX_TILE_BYTES = 1024 * 1024;

  localparam int IDX_W         = $clog2(TABLE_DEPTH);
  localparam int CNT_W         = $clog2(TABLE_DEPTH + 1);
  localparam int ENTRY_COUNT_W = 13;
  localparam int CFG_INDEX_W   = 8;
  localparam int CFG_DATA_W    = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_ENTRY_COUNT = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DATA_BASE   = 8'd1;

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOT_FND  = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_BAD_SIZE = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0]  zoom;
    logic [31:0] col;
    logic [31:0] row;
    logic [31:0] offset;
    logic [31:0] size;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } tbl_wr_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [31:0]      base;
  } search_cfg_t;

endpackage

[src/tibs_table.sv]
// Table storage: one synchronous memory of entries, one write and one read port.
module tibs_table (
  input  logic            clk,
  input  tibs_pkg::tbl_wr_t wr,
  input  logic            rd_en,
  input  logic [tibs_pkg::IDX_W-1:0] rd_addr,
  output tibs_pkg::entry_t rd_data
);
  import tibs_pkg::*;

  entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[src/tibs_search.sv]
// Request sequencer: table loads, binary search probes and the result register.
module tibs_search (
  input  logic                  clk,
  input  logic                  rst,
  input  tibs_pkg::search_cfg_t cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  req_type,
  input  logic [11:0]           slot,
  input  logic [7:0]            zoom_level,
  input  logic [31:0]           tile_col,
  input  logic [31:0]           tile_row,
  input  logic [31:0]           entry_offset,
  input  logic [31:0]           entry_size,
  output tibs_pkg::tbl_wr_t     wr,
  output logic                  rd_en,
  output logic [tibs_pkg::IDX_W-1:0] rd_addr,
  input  tibs_pkg::entry_t      rd_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            status,
  output logic [32:0]           tile_pos,
  output logic [20:0]           tile_size
);
  import tibs_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_PROBE, S_CMP, S_FIN} state_t;

  state_t           state;
  logic [CNT_W-1:0] lo;
  logic [CNT_W-1:0] hi;
  logic [7:0]       key_zoom;
  logic [31:0]      key_col;
  logic [31:0]      key_row;
  status_t          res_status;
  logic [32:0]      res_pos;
  logic [20:0]      res_size;

  logic [CNT_W-1:0] mid;
  logic [CNT_W-1:0] mid_inc;
  logic             key_eq;
  logic             key_lt;
  logic             size_bad;
  logic             accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  assign mid     = lo + ((hi - lo) >> 1);
  assign mid_inc = mid + CNT_W'(1);
  assign rd_en   = (state == S_PROBE);
  assign rd_addr = mid[IDX_W-1:0];

  // Loads write straight into the table on the accepting edge.
  assign wr.en        = accept && (req_type == REQ_LOAD) &&
                        (32'(slot) < 32'(TABLE_DEPTH));
  assign wr.addr      = IDX_W'(slot);
  assign wr.data.zoom   = zoom_level;
  assign wr.data.col    = tile_col;
  assign wr.data.row    = tile_row;
  assign wr.data.offset = entry_offset;
  assign wr.data.size   = entry_size;

  // Key ordering is zoom, then column, then row, all unsigned.
  assign key_eq = (key_zoom == rd_data.zoom) && (key_col == rd_data.col) &&
                  (key_row == rd_data.row);
  assign key_lt = (key_zoom < rd_data.zoom) ||
                  ((key_zoom == rd_data.zoom) &&
                   ((key_col < rd_data.col) ||
                    ((key_col == rd_data.col) && (key_row < rd_data.row))));
  assign size_bad = (rd_data.size == 32'd0) ||
                    (33'(rd_data.size) > 33'(MAX_TILE_BYTES));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && (req_type == REQ_LOOKUP)) begin
            key_zoom <= zoom_level;
            key_col  <= tile_col;
            key_row  <= tile_row;
            lo       <= '0;
            hi       <= cfg.count;
            if (cfg.count == '0) begin
              res_status <= ST_EMPTY;
              res_pos    <= '0;
              res_size   <= '0;
              state      <= S_FIN;
            end else begin
              state <= S_PROBE;
            end
          end
        end
        S_PROBE: begin
          state <= S_CMP;
        end
        S_CMP: begin
          res_pos  <= '0;
          res_size <= '0;
          if (key_eq) begin
            if (size_bad) begin
              res_status <= ST_BAD_SIZE;
            end else begin
              res_status <= ST_OK;
              res_pos    <= {1'b0, cfg.base} + {1'b0, rd_data.offset};
              res_size   <= rd_data.size[20:0];
            end
            state <= S_FIN;
          end else if (key_lt) begin
            hi <= mid;
            if (lo >= mid) begin
              res_status <= ST_NOT_FND;
              state      <= S_FIN;
            end else begin
              state <= S_PROBE;
            end
          end else begin
            lo <= mid_inc;
            if (mid_inc >= hi) begin
              res_status <= ST_NOT_FND;
              state      <= S_FIN;
            end else begin
              state <= S_PROBE;
            end
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            status    <= res_status;
            tile_pos  <= res_pos;
            tile_size <= res_size;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[src/tile_index_binary_search_core.sv]
// Top level of the tile index binary search block: configuration and wiring.
// A load beat writes its table entry at the edge on which it is taken.
// A lookup does a memory read, then a compare, for each probe, then loads the
// output registers, with at most ceil(log2(entry_count + 1)) probes.
// One item is worked on at a time; the result register frees the input side.
// Synchronous reset clears the control state, out_valid and the configuration
// registers; table contents stay undefined until loaded.
module tile_index_binary_search_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [tibs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tibs_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [11:0] slot,
  input  logic [7:0]  zoom_level,
  input  logic [31:0] tile_col,
  input  logic [31:0] tile_row,
  input  logic [31:0] entry_offset,
  input  logic [31:0] entry_size,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [32:0] tile_pos,
  output logic [20:0] tile_size
);
  import tibs_pkg::*;

  logic [ENTRY_COUNT_W-1:0] entry_count;
  logic [31:0]              data_base;
  search_cfg_t              cfg;
  tbl_wr_t                  wr;
  logic                     rd_en;
  logic [IDX_W-1:0]         rd_addr;
  entry_t                   rd_data;

  // Configuration beats are always taken; software must write only while idle, which the block does not enforce.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      data_base   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ENTRY_COUNT: entry_count <= cfg_data[ENTRY_COUNT_W-1:0];
        REG_DATA_BASE:   data_base   <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // A count beyond the table depth searches the whole table.
  assign cfg.count = (32'(entry_count) > 32'(TABLE_DEPTH)) ?
                     CNT_W'(TABLE_DEPTH) : CNT_W'(entry_count);
  assign cfg.base  = data_base;

  tibs_table u_table (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tibs_search u_search (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .slot         (slot),
    .zoom_level   (zoom_level),
    .tile_col     (tile_col),
    .tile_row     (tile_row),
    .entry_offset (entry_offset),
    .entry_size   (entry_size),
    .wr           (wr),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .tile_pos     (tile_pos),
    .tile_size    (tile_size)
  );

endmodule
